/* sv/sgm_pkg.sv */
package sgm_pkg;
    localparam int MAX_LINE_PIXELS_DEF = 1024;
    localparam int CH_W = 8;
    localparam int NUM_LANES = 3;
    localparam int PIX_W = CH_W * NUM_LANES;
    localparam int WIDTH_W = 11;
    localparam int HEIGHT_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd768;
    // Sobel sums fit in 11 bits signed (|g| <= 1020)
    localparam int GRAD_W = 11;
    localparam int SQ_W = 21;

    typedef struct packed {
        logic [CH_W-1:0] a0;
        logic [CH_W-1:0] a1;
        logic [CH_W-1:0] a2;
        logic [CH_W-1:0] b0;
        logic [CH_W-1:0] b2;
        logic [CH_W-1:0] c0;
        logic [CH_W-1:0] c1;
        logic [CH_W-1:0] c2;
    } win_t;
endpackage

/* sv/sgm_stream_if.sv */
interface sgm_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/sgm_cfg_if.sv */
interface sgm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sgm_pkg::CFG_IDX_W-1:0]  index;
    logic [sgm_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/sgm_ram.sv */
module sgm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end
endmodule

/* sv/sgm_lane.sv */
// One channel: gradients -> squares -> 8-step restoring isqrt, pipelined.
module sgm_lane (
    input  logic                 clk,
    input  logic                 en,
    input  sgm_pkg::win_t        win,
    output logic [sgm_pkg::CH_W-1:0] mag
);
    import sgm_pkg::*;

    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic [SQ_W:0]             sum_reg;
    logic signed [GRAD_W-1:0] gx_next, gy_next;

    always_comb
    begin
        gx_next = (GRAD_W'(win.a2) + (GRAD_W'(win.b2) <<< 1) + GRAD_W'(win.c2))
                - (GRAD_W'(win.a0) + (GRAD_W'(win.b0) <<< 1) + GRAD_W'(win.c0));
        gy_next = (GRAD_W'(win.c0) + (GRAD_W'(win.c1) <<< 1) + GRAD_W'(win.c2))
                - (GRAD_W'(win.a0) + (GRAD_W'(win.a1) <<< 1) + GRAD_W'(win.a2));
    end

    logic [2*GRAD_W-1:0] sqx, sqy;
    assign sqx = (2*GRAD_W)'(gx_reg * gx_reg);
    assign sqy = (2*GRAD_W)'(gy_reg * gy_reg);

    // isqrt stages: one bit per stage, 128 down to 1
    logic [SQ_W:0]   s_reg [9];
    logic [CH_W-1:0] r_reg [9];
    logic            sat_reg [9];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gx_reg   <= gx_next;
            gy_reg   <= gy_next;
            sum_reg  <= (SQ_W+1)'(sqx[SQ_W-1:0]) + (SQ_W+1)'(sqy[SQ_W-1:0]);
            s_reg[0]   <= sum_reg;
            r_reg[0]   <= '0;
            sat_reg[0] <= (sum_reg >= (SQ_W+1)'(65536));
            for (int i = 0; i < 8; i++)
            begin
                logic [CH_W-1:0] t;
                t = r_reg[i] | CH_W'(8'd128 >> i);
                s_reg[i+1]   <= s_reg[i];
                sat_reg[i+1] <= sat_reg[i];
                if ((SQ_W+1)'(t) * (SQ_W+1)'(t) <= s_reg[i])
                    r_reg[i+1] <= t;
                else
                    r_reg[i+1] <= r_reg[i];
            end
        end
    end

    assign mag = sat_reg[8] ? 8'd255 : r_reg[8];
endmodule

/* sv/sgm_window.sv */
// Line stores, 3x3 window, position counters.
module sgm_window #(
    parameter int MAX_LINE_PIXELS = sgm_pkg::MAX_LINE_PIXELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         take,
    input  logic [sgm_pkg::PIX_W-1:0]    px,
    input  logic [sgm_pkg::WIDTH_W-1:0]  image_width,
    input  logic [sgm_pkg::HEIGHT_W-1:0] image_height,
    output logic [sgm_pkg::PIX_W-1:0]    win [9],
    output logic                         win_valid,
    output logic                         win_last
);
    import sgm_pkg::*;
    localparam int AW = $clog2(MAX_LINE_PIXELS);
    localparam int CW = AW + 1;

    logic [CW-1:0]       col_reg;
    logic [HEIGHT_W-1:0] row_reg;
    logic [PIX_W-1:0]    px_reg;
    logic                v_reg, last_reg;
    logic [PIX_W-1:0]    up_q, mid_q;
    logic [PIX_W-1:0]    w_reg [9];
    logic                wv_reg, wl_reg;
    logic [AW-1:0]       addr;
    logic [AW-1:0]       addr_reg;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic                row_end, frame_end;
    // window shift happens for every accepted pixel; tracked separately
    logic                sh_reg;

    always_comb
    begin
        if (image_width < WIDTH_W'(3))
            w_eff = WIDTH_W'(3);
        else if (32'(image_width) > MAX_LINE_PIXELS)
            w_eff = WIDTH_W'(MAX_LINE_PIXELS);
        else
            w_eff = image_width;
        h_eff = (image_height < HEIGHT_W'(3)) ? HEIGHT_W'(3) : image_height;
        addr = (32'(col_reg) >= MAX_LINE_PIXELS) ? AW'(MAX_LINE_PIXELS - 1)
                                                   : col_reg[AW-1:0];
        row_end = 32'(col_reg) >= 32'(w_eff) - 1;
        frame_end = row_end && (row_reg >= h_eff - HEIGHT_W'(1));
    end

    // read at take, write back in the next enabled cycle (same address)
    sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE_PIXELS)) u_up (
        .clk(clk), .we(en && sh_reg), .waddr(addr_reg), .wdata(mid_q),
        .re(take), .raddr(addr), .rdata(up_q)
    );
    sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE_PIXELS)) u_mid (
        .clk(clk), .we(en && sh_reg), .waddr(addr_reg), .wdata(px_reg),
        .re(take), .raddr(addr), .rdata(mid_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            v_reg    <= 1'b0;
            wv_reg   <= 1'b0;
            last_reg <= 1'b0;
            wl_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                if (row_end)
                begin
                    col_reg <= '0;
                    row_reg <= frame_end ? '0 : row_reg + HEIGHT_W'(1);
                end
                else
                    col_reg <= col_reg + CW'(1);
                px_reg   <= px;
                addr_reg <= addr;
                last_reg <= frame_end;
            end
            if (en)
            begin
                if (take)
                    v_reg <= (row_reg >= HEIGHT_W'(2)) && (col_reg >= CW'(2));
                else
                    v_reg <= 1'b0;
                wv_reg <= v_reg;
                wl_reg <= v_reg && last_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sh_reg <= 1'b0;
        else if (en)
            sh_reg <= take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                w_reg[i] <= '0;
        end
        else if (en && sh_reg)
        begin
            w_reg[0] <= w_reg[1]; w_reg[1] <= w_reg[2]; w_reg[2] <= up_q;
            w_reg[3] <= w_reg[4]; w_reg[4] <= w_reg[5]; w_reg[5] <= mid_q;
            w_reg[6] <= w_reg[7]; w_reg[7] <= w_reg[8]; w_reg[8] <= px_reg;
        end
    end

    assign win       = w_reg;
    assign win_valid = wv_reg;
    assign win_last  = wl_reg;
endmodule

/* sv/sobel_gradient_magnitude_rgb.sv */
// Sobel 3x3 gradient magnitude on a 24-bit RGB raster stream.
// Channels: pixel_in (sink) carries first/second/third_channel, one pixel per
// request in raster order; result_out (source) carries the three saturated
// magnitudes and last_of_frame; cfg (sink) writes image_width (index 0) and
// image_height (index 1); the user writes only while the block is idle, unchecked.
// Throughput: one pixel per cycle unless the output stalls. The whole
// datapath is a single pipeline that advances on one enable, so nothing is
// ever dropped. A result is offered once the pixel below-right of its center
// has passed 1 line-store read, 1 window load, 3 arithmetic stages
// (gradients, summed squares, root seed) and 8 square root stages; the last
// root stage is the output register. Border pixels give no result.
// Reset: counters and window clear, registers return to 1024 x 768; line
// stores are not cleared (a frame writes each entry before a result uses it).
// Stall: when the result is not taken the pipeline freezes and pixel_in
// ready drops; it is accepted again as soon as the output register drains.
module sobel_gradient_magnitude_rgb #(
    parameter int MAX_LINE_PIXELS = sgm_pkg::MAX_LINE_PIXELS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    sgm_stream_if.sink   pixel_in,
    sgm_stream_if.source result_out,
    sgm_cfg_if.sink      cfg
);
    import sgm_pkg::*;
    localparam int DEPTH = 11;

    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;
    logic                en, take;
    logic [PIX_W-1:0]    win [9];
    logic                win_valid, win_last;
    logic [DEPTH-1:0]    vpipe_reg, lpipe_reg;
    logic [CH_W-1:0]     mag [NUM_LANES];

    // pipeline moves unless the final result is stuck
    assign en   = !(result_out.valid && !result_out.ready);
    assign take = en && pixel_in.valid;
    assign pixel_in.ready = en;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg.data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg.data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    sgm_window #(.MAX_LINE_PIXELS(MAX_LINE_PIXELS)) u_win (
        .clk(clk), .rst_n(rst_n), .en(en), .take(take), .px(pixel_in.data),
        .image_width(image_width_reg), .image_height(image_height_reg),
        .win(win), .win_valid(win_valid), .win_last(win_last)
    );

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        win_t w;
        assign w = '{a0: win[0][g*CH_W +: CH_W], a1: win[1][g*CH_W +: CH_W],
                     a2: win[2][g*CH_W +: CH_W], b0: win[3][g*CH_W +: CH_W],
                     b2: win[5][g*CH_W +: CH_W], c0: win[6][g*CH_W +: CH_W],
                     c1: win[7][g*CH_W +: CH_W], c2: win[8][g*CH_W +: CH_W]};
        sgm_lane u_lane (.clk(clk), .en(en), .win(w), .mag(mag[g]));
    end

    // valid/last tags travel alongside the lanes (11 lane stages)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vpipe_reg <= '0;
            lpipe_reg <= '0;
        end
        else if (en)
        begin
            vpipe_reg <= {vpipe_reg[DEPTH-2:0], win_valid};
            lpipe_reg <= {lpipe_reg[DEPTH-2:0], win_last};
        end
    end

    // merge: lane outputs join into one result word
    assign result_out.valid = vpipe_reg[DEPTH-1];
    assign result_out.data  = {lpipe_reg[DEPTH-1], mag[2], mag[1], mag[0]};

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && !result_out.ready |=> result_out.valid
            && $stable(result_out.data))
        else $error("result changed under stall");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && !result_out.ready |-> !pixel_in.ready)
        else $error("pixel taken while stalled");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.data[PIX_W] |-> result_out.valid)
        else $error("last flag without result");
endmodule

/* sim/sobel_gradient_magnitude_rgb_test.sv */
module sobel_gradient_magnitude_rgb_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sgm_pkg::*;

    localparam int RES_W = PIX_W + 1;      // {last_of_frame, third, second, first}
    localparam int SETTLE_CYCLES = 20;     // exceeds the pipeline depth
    localparam int STALL_LIMIT = 20000;    // cycles without any accepted request

    typedef struct packed {
        logic            last;
        logic [CH_W-1:0] mag2;
        logic [CH_W-1:0] mag1;
        logic [CH_W-1:0] mag0;
    } edge_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sgm_stream_if #(.W(PIX_W)) pixel_in ();
    sgm_stream_if #(.W(RES_W)) result_out ();
    sgm_cfg_if cfg ();

    sobel_gradient_magnitude_rgb i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .pixel_in(pixel_in),
        .result_out(result_out),
        .cfg(cfg)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Mirror of the block: line stores, window, raster position, regs
    // ---------------------------------------------------------------
    logic [PIX_W-1:0]    upper_row [MAX_LINE_PIXELS_DEF];
    logic [PIX_W-1:0]    middle_row [MAX_LINE_PIXELS_DEF];
    logic [PIX_W-1:0]    window [9];
    int unsigned         col_pos;
    int unsigned         row_pos;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    edge_result_t expected_edges[$];
    int   error_count = 0;
    bit   send_idle = 1'b1;   // sender inserts random gaps
    bit   recv_idle = 1'b1;   // receiver drops ready at random
    int   recv_hold = 0;      // long receiver hold-off, in cycles
    int   quiet_cycles = 0;

    function automatic logic [CH_W-1:0] root_sat(int unsigned s);
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] t;
        r = '0;
        if (s >= 65536)
            return 8'd255;
        for (int b = CH_W - 1; b >= 0; b--)
        begin
            t = r | (8'd1 << b);
            if (int'(t) * int'(t) <= s)
                r = t;
        end
        return r;
    endfunction

    function automatic int lane(logic [PIX_W-1:0] p, int k);
        return int'(p[k*CH_W +: CH_W]);
    endfunction

    function automatic logic [CH_W-1:0] lane_magnitude(int k);
        int gx;
        int gy;
        gx = (lane(window[2], k) + 2 * lane(window[5], k) + lane(window[8], k))
           - (lane(window[0], k) + 2 * lane(window[3], k) + lane(window[6], k));
        gy = (lane(window[6], k) + 2 * lane(window[7], k) + lane(window[8], k))
           - (lane(window[0], k) + 2 * lane(window[1], k) + lane(window[2], k));
        return root_sat(gx * gx + gy * gy);
    endfunction

    function automatic void reset_edge_mirror();
        foreach (upper_row[i]) upper_row[i] = '0;
        foreach (middle_row[i]) middle_row[i] = '0;
        foreach (window[i]) window[i] = '0;
        col_pos = 0;
        row_pos = 0;
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
    endfunction

    // Advance the mirror by one accepted pixel; queue the result it produces.
    function automatic void predict_edge(logic [PIX_W-1:0] px);
        int unsigned  w_eff;
        int unsigned  h_eff;
        int unsigned  c;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        bit           row_end;
        bit           frame_end;
        edge_result_t res;
        w_eff = width_reg;
        h_eff = height_reg;
        if (w_eff < 3) w_eff = 3;
        if (w_eff > MAX_LINE_PIXELS_DEF) w_eff = MAX_LINE_PIXELS_DEF;
        if (h_eff < 3) h_eff = 3;
        c = (col_pos >= MAX_LINE_PIXELS_DEF) ? MAX_LINE_PIXELS_DEF - 1 : col_pos;
        up = upper_row[c];
        mid = middle_row[c];
        upper_row[c] = mid;
        middle_row[c] = px;
        window[0] = window[1]; window[1] = window[2]; window[2] = up;
        window[3] = window[4]; window[4] = window[5]; window[5] = mid;
        window[6] = window[7]; window[7] = window[8]; window[8] = px;
        row_end = col_pos >= w_eff - 1;
        frame_end = row_end && row_pos >= h_eff - 1;
        if (row_pos >= 2 && col_pos >= 2)
        begin
            res.mag0 = lane_magnitude(0);
            res.mag1 = lane_magnitude(1);
            res.mag2 = lane_magnitude(2);
            res.last = frame_end;
            expected_edges.push_back(res);
        end
        if (row_end)
        begin
            col_pos = 0;
            row_pos = frame_end ? 0 : (row_pos + 1) & 16'hFFFF;
        end
        else
            col_pos++;
    endfunction

    // ---------------------------------------------------------------
    // Drivers (change at falling edge, sample at rising edge)
    // ---------------------------------------------------------------
    task automatic send_pixel(logic [CH_W-1:0] b0, logic [CH_W-1:0] b1,
                              logic [CH_W-1:0] b2);
        if (send_idle)
            while ($urandom_range(99) < 23)
            begin
                @(negedge clk);
                pixel_in.valid = 1'b0;
                @(posedge clk);
            end
        @(negedge clk);
        pixel_in.valid = 1'b1;
        pixel_in.data = {b2, b1, b0};
        do
            @(posedge clk);
        while (!pixel_in.ready);
        predict_edge({b2, b1, b0});
    endtask

    task automatic send_random_pixel();
        send_pixel(CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
                   CH_W'($urandom_range(255)));
    endtask

    task automatic stop_pixels();
        @(negedge clk);
        pixel_in.valid = 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data = value;
        do
            @(posedge clk);
        while (!cfg.ready);
        if (idx == REG_IMAGE_WIDTH)
            width_reg = value[WIDTH_W-1:0];
        else
            height_reg = value[HEIGHT_W-1:0];
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // Wait for every queued result, then let any borderless pixels flush.
    task automatic drain_results();
        stop_pixels();
        while (expected_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame(int unsigned w, int unsigned h);
        drain_results();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    endtask

    // Finish the frame in progress with random pixels.
    task automatic finish_frame();
        while (col_pos != 0 || row_pos != 0)
            send_random_pixel();
    endtask

    // Receiver: random ready, or a counted hold-off when requested.
    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            result_out.ready = 1'b0;
            recv_hold = recv_hold - 1;
        end
        else
            result_out.ready = !recv_idle || ($urandom_range(99) >= 23);
    end

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        edge_result_t got;
        edge_result_t want;
        if (rst_n && result_out.valid && result_out.ready)
        begin
            got = result_out.data;
            if (expected_edges.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h", $realtime, got);
                error_count++;
            end
            else
            begin
                want = expected_edges.pop_front();
                if (got.mag0 !== want.mag0)
                begin
                    $display("%0t: first_magnitude expected %0d actual %0d",
                             $realtime, want.mag0, got.mag0);
                    error_count++;
                end
                if (got.mag1 !== want.mag1)
                begin
                    $display("%0t: second_magnitude expected %0d actual %0d",
                             $realtime, want.mag1, got.mag1);
                    error_count++;
                end
                if (got.mag2 !== want.mag2)
                begin
                    $display("%0t: third_magnitude expected %0d actual %0d",
                             $realtime, want.mag2, got.mag2);
                    error_count++;
                end
                if (got.last !== want.last)
                begin
                    $display("%0t: last_of_frame expected %0b actual %0b",
                             $realtime, want.last, got.last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no request moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((pixel_in.valid && pixel_in.ready) || (result_out.valid && result_out.ready)
            || (cfg.valid && cfg.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $realtime,
                     expected_edges.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // 3x3 frames: flat, sharp edges per channel, full saturation. Width and
    // height below range clamp to 3.
    task automatic test_directed_frames();
        set_frame(2, 1);
        for (int i = 0; i < 9; i++)
            send_pixel(8'd0, 8'd0, 8'd0);
        // vertical edge on byte 0, horizontal edge on byte 1, checker on byte 2
        for (int i = 0; i < 9; i++)
            send_pixel((i % 3 == 2) ? 8'd255 : 8'd0, (i >= 6) ? 8'd255 : 8'd0,
                       (i % 2 == 0) ? 8'd255 : 8'd0);
        // corner on bytes 0 and 1: |gx| and |gy| both large, root saturates; byte 2 flat
        for (int i = 0; i < 9; i++)
            send_pixel((i % 3 == 2 || i >= 6) ? 8'd255 : 8'd0,
                       (i % 3 == 0 || i < 3) ? 8'd255 : 8'd0, 8'd255);
    endtask

    // Largest register values (width clamps to the line store size), then
    // narrow both in mid frame so the counters sit past the new row end.
    task automatic test_register_extremes();
        set_frame(11'h7FF, 16'hFFFF);
        for (int i = 0; i < 30; i++)
            send_random_pixel();
        drain_results();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
        finish_frame();
    endtask

    // Counters are not cleared by a write: narrow the row in mid frame.
    task automatic test_mid_frame_write();
        set_frame(9, 6);
        for (int i = 0; i < 23; i++)
            send_random_pixel();
        drain_results();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(5));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(4));
        finish_frame();
    endtask

    // Receiver holds off long enough to fill the pipeline and stall the input.
    task automatic test_backpressure();
        set_frame(10, 10);
        recv_hold = 250;
        for (int i = 0; i < 100; i++)
            send_random_pixel();
    endtask

    // Random frame sizes and content; first stretch runs with no gaps at all.
    task automatic test_random_frames();
        int sent;
        sent = 0;
        send_idle = 1'b0;
        recv_idle = 1'b0;
        while (sent < 200)
        begin
            if (sent > 120)
            begin
                send_idle = 1'b1;
                recv_idle = 1'b1;
            end
            set_frame($urandom_range(3, 12), $urandom_range(3, 8));
            do
            begin
                case ($urandom_range(9))
                    0: send_pixel(8'd0, 8'd0, 8'd0);
                    1: send_pixel(8'd255, 8'd255, 8'd255);
                    default: send_random_pixel();
                endcase
                sent++;
            end
            while (col_pos != 0 || row_pos != 0);
        end
    endtask

    initial
    begin
        pixel_in.valid = 1'b0;
        pixel_in.data = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_IMAGE_WIDTH;
        cfg.data = '0;
        result_out.ready = 1'b0;
        reset_edge_mirror();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_frames();
        test_register_extremes();
        test_mid_frame_write();
        test_backpressure();
        test_random_frames();
        drain_results();

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
